// File: rtl/core/sdtq_pkg.sv
// Shared types and constants for the sorted deadline timer queue.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package sdtq_pkg;

    localparam int MAX_TIMERS_DEF = 16;

    localparam int TIME_W     = 48;
    localparam int WAIT_W     = 31;
    localparam int MIN_IV_W   = 10;
    localparam int IDLE_W     = 16;
    localparam int STATUS_W   = 3;
    localparam int ID_W       = 4;
    localparam int CMD_W      = 2;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_PAD_W  = OUT_DATA_W - STATUS_W - ID_W - WAIT_W;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_WAIT    = 1'b1;

    localparam logic [MIN_IV_W-1:0] MIN_IV_RST = 10'd5;
    localparam logic [IDLE_W-1:0]   IDLE_RST   = 16'd100;
    localparam logic [WAIT_W-1:0]   WAIT_MAX   = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_TAKE   = 2'd1,
        CMD_FINISH = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_NONE_DUE = 3'd1,
        ST_FULL     = 3'd2,
        ST_SHORT    = 3'd3,
        ST_NOT_HELD = 3'd4
    } status_t;

    // controller -> datapath, at most one step bit high per cycle
    typedef struct packed {
        logic latch;
        logic decode;
        logic scan;
        logic take_rd;
        logic take_chk;
        logic take_arm;
        logic pop;
        logic ins;
        logic front_rd;
        logic result;
    } dp_ctl_t;

    // datapath -> controller
    typedef struct packed {
        cmd_t cmd;
        logic short_iv;
        logic held;
        logic keep;
        logic empty;
        logic scan_free;
        logic scan_last;
        logic due;
        logic pop_done;
        logic ins_done;
        logic out_free;
    } dp_stat_t;

endpackage

// File: rtl/core/sdtq_ctrl.sv
// Sequencing state machine for the timer queue.
// Depends on sdtq_pkg; drives the step bits of sdtq_datapath.
`timescale 1ns / 1ps

module sdtq_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  sdtq_pkg::dp_stat_t stat,
    output sdtq_pkg::dp_ctl_t  ctl
);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b0000000001,
        S_DECODE   = 10'b0000000010,
        S_SCAN     = 10'b0000000100,
        S_TAKE_RD  = 10'b0000001000,
        S_TAKE_CHK = 10'b0000010000,
        S_TAKE_ARM = 10'b0000100000,
        S_POP      = 10'b0001000000,
        S_INS      = 10'b0010000000,
        S_FRONT_RD = 10'b0100000000,
        S_RESULT   = 10'b1000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        ctl          = '0;
        ctl.latch    = (state_reg == S_IDLE) && s_tvalid;
        ctl.decode   = (state_reg == S_DECODE);
        ctl.scan     = (state_reg == S_SCAN);
        ctl.take_rd  = (state_reg == S_TAKE_RD);
        ctl.take_chk = (state_reg == S_TAKE_CHK);
        ctl.take_arm = (state_reg == S_TAKE_ARM);
        ctl.pop      = (state_reg == S_POP);
        ctl.ins      = (state_reg == S_INS);
        ctl.front_rd = (state_reg == S_FRONT_RD);
        ctl.result   = (state_reg == S_RESULT);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                case (stat.cmd)
                    sdtq_pkg::CMD_ADD:
                        state_next = stat.short_iv ? S_FRONT_RD : S_SCAN;
                    sdtq_pkg::CMD_TAKE:
                        state_next = (!stat.held && !stat.empty) ? S_TAKE_RD : S_FRONT_RD;
                    sdtq_pkg::CMD_FINISH:
                        state_next = (stat.held && stat.keep) ? S_INS : S_FRONT_RD;
                    default:
                        state_next = S_FRONT_RD;
                endcase
            end
            S_SCAN:
            begin
                if (stat.scan_free)
                    state_next = S_INS;
                else if (stat.scan_last)
                    state_next = S_FRONT_RD;
            end
            S_TAKE_RD:
                state_next = S_TAKE_CHK;
            S_TAKE_CHK:
                state_next = stat.due ? S_TAKE_ARM : S_FRONT_RD;
            S_TAKE_ARM:
                state_next = S_POP;
            S_POP:
            begin
                if (stat.pop_done)
                    state_next = S_FRONT_RD;
            end
            S_INS:
            begin
                if (stat.ins_done)
                    state_next = S_FRONT_RD;
            end
            S_FRONT_RD:
                state_next = S_RESULT;
            S_RESULT:
            begin
                if (stat.out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// File: rtl/core/sdtq_datapath.sv
// Datapath of the timer queue: order memory of {deadline, slot} by position,
// period memory by slot, slot bitmap, held timer, config and output register.
// Depends on sdtq_pkg; stepped by sdtq_ctrl.
`timescale 1ns / 1ps

module sdtq_datapath
#(
    parameter int MAX_TIMERS = sdtq_pkg::MAX_TIMERS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  sdtq_pkg::dp_ctl_t                 ctl,
    output sdtq_pkg::dp_stat_t                stat,
    input  logic [sdtq_pkg::CMD_W-1:0]        s_tuser,
    input  logic [sdtq_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [sdtq_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  logic                              cfg_we,
    input  logic [sdtq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sdtq_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int SLOT_W = $clog2(MAX_TIMERS);
    localparam int CNT_W  = $clog2(MAX_TIMERS + 1);
    localparam int TIME_W = sdtq_pkg::TIME_W;
    localparam int WAIT_W = sdtq_pkg::WAIT_W;

    typedef struct packed {
        logic [TIME_W-1:0] dl;
        logic [SLOT_W-1:0] slot;
    } entry_t;

    function automatic logic [TIME_W-1:0] arm_time(input logic [TIME_W-1:0] now,
                                                  input logic [WAIT_W-1:0] per);
        logic [TIME_W:0] sum;
        sum = {1'b0, now} + {{(TIME_W - WAIT_W + 1){1'b0}}, per};
        arm_time = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
    endfunction

    // memories
    entry_t            ord_mem [MAX_TIMERS];
    logic [WAIT_W-1:0] per_mem [MAX_TIMERS];
    entry_t            ord_rd;
    logic [WAIT_W-1:0] per_rd;
    logic              ord_we, ord_re, per_we, per_re;
    logic [SLOT_W-1:0] ord_wa, ord_ra, per_wa, per_ra;
    entry_t            ord_wd;

    // control state
    logic [sdtq_pkg::MIN_IV_W-1:0] min_iv_reg;
    logic [sdtq_pkg::IDLE_W-1:0]   idle_reg;
    logic [MAX_TIMERS-1:0]         in_use_reg, in_use_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic                          held_valid_reg, held_valid_next;
    logic [SLOT_W-1:0]             held_slot_reg, held_slot_next;
    logic [CNT_W-1:0]              idx_reg, idx_next;
    logic                          pend_reg, pend_next;
    logic                          out_valid_reg, out_valid_next;

    // payload
    sdtq_pkg::cmd_t     cmd_reg, cmd_next;
    logic [TIME_W-1:0]  now_reg, now_next;
    logic [WAIT_W-1:0]  iv_reg, iv_next;
    logic               keep_reg, keep_next;
    logic [TIME_W-1:0]  held_dl_reg, held_dl_next;
    entry_t             new_reg, new_next;
    sdtq_pkg::status_t  status_reg, status_next;
    logic [SLOT_W-1:0]  id_reg, id_next;
    sdtq_pkg::status_t  out_status_reg, out_status_next;
    logic [SLOT_W-1:0]  out_id_reg, out_id_next;
    logic [WAIT_W-1:0]  out_wait_reg, out_wait_next;

    logic [SLOT_W-1:0] scan_slot;
    logic              short_iv, slot_free, due, ins_gt, ins_done, pop_done, out_free;
    logic [CNT_W-1:0]  idx_m1, idx_m2, idx_p1;
    logic [TIME_W-1:0] diff;
    logic [WAIT_W-1:0] wait_val;

    assign scan_slot = idx_reg[SLOT_W-1:0];
    assign short_iv  = iv_reg < WAIT_W'(min_iv_reg);
    assign slot_free = !in_use_reg[scan_slot];
    assign due       = ord_rd.dl <= now_reg;
    assign ins_gt    = ord_rd.dl > new_reg.dl;
    assign ins_done  = pend_reg ? !ins_gt : (idx_reg == '0);
    assign pop_done  = idx_reg >= count_reg;
    assign out_free  = !out_valid_reg || m_tready;
    assign idx_m1    = idx_reg - CNT_W'(1);
    assign idx_m2    = idx_reg - CNT_W'(2);
    assign idx_p1    = idx_reg + CNT_W'(1);
    assign diff      = ord_rd.dl - now_reg;

    always_comb
    begin
        if (count_reg == '0)
            wait_val = (idle_reg == '0) ? WAIT_W'(1) : WAIT_W'(idle_reg);
        else if (due)
            wait_val = WAIT_W'(1);
        else if (diff > TIME_W'(sdtq_pkg::WAIT_MAX))
            wait_val = sdtq_pkg::WAIT_MAX;
        else
            wait_val = diff[WAIT_W-1:0];
    end

    always_comb
    begin
        stat.cmd       = cmd_reg;
        stat.short_iv  = short_iv;
        stat.held      = held_valid_reg;
        stat.keep      = keep_reg;
        stat.empty     = (count_reg == '0);
        stat.scan_free = slot_free;
        stat.scan_last = (idx_reg == CNT_W'(MAX_TIMERS - 1));
        stat.due       = due;
        stat.pop_done  = pop_done;
        stat.ins_done  = ins_done;
        stat.out_free  = out_free;
    end

    always_comb
    begin
        in_use_next     = in_use_reg;
        count_next      = count_reg;
        held_valid_next = held_valid_reg;
        held_slot_next  = held_slot_reg;
        idx_next        = idx_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        cmd_next        = cmd_reg;
        now_next        = now_reg;
        iv_next         = iv_reg;
        keep_next       = keep_reg;
        held_dl_next    = held_dl_reg;
        new_next        = new_reg;
        status_next     = status_reg;
        id_next         = id_reg;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_wait_next   = out_wait_reg;

        ord_we = 1'b0;
        ord_wa = '0;
        ord_wd = new_reg;
        ord_re = 1'b0;
        ord_ra = '0;
        per_we = 1'b0;
        per_wa = scan_slot;
        per_re = 1'b0;
        per_ra = ord_rd.slot;

        if (ctl.latch)
        begin
            cmd_next  = sdtq_pkg::cmd_t'(s_tuser);
            now_next  = s_tdata[TIME_W-1:0];
            iv_next   = s_tdata[TIME_W+WAIT_W-1:TIME_W];
            keep_next = s_tdata[TIME_W+WAIT_W];
        end

        if (ctl.decode)
        begin
            status_next = sdtq_pkg::ST_NONE_DUE;
            id_next     = '0;
            case (cmd_reg)
                sdtq_pkg::CMD_ADD:
                begin
                    if (short_iv)
                        status_next = sdtq_pkg::ST_SHORT;
                    else
                    begin
                        status_next = sdtq_pkg::ST_FULL;
                        idx_next    = '0;
                    end
                end
                sdtq_pkg::CMD_FINISH:
                begin
                    if (!held_valid_reg)
                        status_next = sdtq_pkg::ST_NOT_HELD;
                    else
                    begin
                        status_next     = sdtq_pkg::ST_OK;
                        id_next         = held_slot_reg;
                        held_valid_next = 1'b0;
                        if (keep_reg)
                        begin
                            new_next.dl   = held_dl_reg;
                            new_next.slot = held_slot_reg;
                            idx_next      = count_reg;
                            pend_next     = 1'b0;
                        end
                        else
                            in_use_next[held_slot_reg] = 1'b0;
                    end
                end
                default:
                    status_next = sdtq_pkg::ST_NONE_DUE;
            endcase
        end

        if (ctl.scan)
        begin
            if (slot_free)
            begin
                in_use_next[scan_slot] = 1'b1;
                per_we        = 1'b1;
                new_next.slot = scan_slot;
                new_next.dl   = arm_time(now_reg, iv_reg);
                status_next   = sdtq_pkg::ST_OK;
                id_next       = scan_slot;
                idx_next      = count_reg;
                pend_next     = 1'b0;
            end
            else
                idx_next = idx_p1;
        end

        if (ctl.take_rd)
            ord_re = 1'b1;

        if (ctl.take_chk && due)
        begin
            held_slot_next  = ord_rd.slot;
            held_valid_next = 1'b1;
            per_re          = 1'b1;
            status_next     = sdtq_pkg::ST_OK;
            id_next         = ord_rd.slot;
        end

        if (ctl.take_arm)
        begin
            held_dl_next = arm_time(now_reg, per_rd);
            idx_next     = CNT_W'(1);
            pend_next    = 1'b0;
        end

        // shift the list down by one: read position idx, write it at idx-1
        if (ctl.pop)
        begin
            if (pend_reg)
            begin
                ord_we = 1'b1;
                ord_wa = idx_m2[SLOT_W-1:0];
                ord_wd = ord_rd;
            end
            if (!pop_done)
            begin
                ord_re    = 1'b1;
                ord_ra    = idx_reg[SLOT_W-1:0];
                idx_next  = idx_p1;
                pend_next = 1'b1;
            end
            else
            begin
                pend_next  = 1'b0;
                count_next = count_reg - CNT_W'(1);
            end
        end

        // walk from the tail, moving later deadlines up one place
        if (ctl.ins)
        begin
            if (pend_reg)
            begin
                ord_we = 1'b1;
                ord_wa = idx_p1[SLOT_W-1:0];
                ord_wd = ins_gt ? ord_rd : new_reg;
            end
            if (!pend_reg || ins_gt)
            begin
                if (idx_reg != '0)
                begin
                    ord_re    = 1'b1;
                    ord_ra    = idx_m1[SLOT_W-1:0];
                    idx_next  = idx_m1;
                    pend_next = 1'b1;
                end
                else if (pend_reg)
                    pend_next = 1'b0;
                else
                begin
                    ord_we = 1'b1;
                    ord_wa = '0;
                    ord_wd = new_reg;
                end
            end
            if (ins_done)
                count_next = count_reg + CNT_W'(1);
        end

        if (ctl.front_rd)
            ord_re = 1'b1;

        if (ctl.result && out_free)
        begin
            out_valid_next  = 1'b1;
            out_status_next = status_reg;
            out_id_next     = id_reg;
            out_wait_next   = wait_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ord_we)
            ord_mem[ord_wa] <= ord_wd;
        if (ord_re)
            ord_rd <= ord_mem[ord_ra];
        if (per_we)
            per_mem[per_wa] <= iv_reg;
        if (per_re)
            per_rd <= per_mem[per_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_iv_reg     <= sdtq_pkg::MIN_IV_RST;
            idle_reg       <= sdtq_pkg::IDLE_RST;
            in_use_reg     <= '0;
            count_reg      <= '0;
            held_valid_reg <= 1'b0;
            held_slot_reg  <= '0;
            idx_reg        <= '0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    sdtq_pkg::CFG_MIN_INTERVAL:
                        min_iv_reg <= cfg_data[sdtq_pkg::MIN_IV_W-1:0];
                    sdtq_pkg::CFG_IDLE_WAIT:
                        idle_reg <= cfg_data[sdtq_pkg::IDLE_W-1:0];
                    default:
                        idle_reg <= idle_reg;
                endcase
            end
            in_use_reg     <= in_use_next;
            count_reg      <= count_next;
            held_valid_reg <= held_valid_next;
            held_slot_reg  <= held_slot_next;
            idx_reg        <= idx_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        now_reg        <= now_next;
        iv_reg         <= iv_next;
        keep_reg       <= keep_next;
        held_dl_reg    <= held_dl_next;
        new_reg        <= new_next;
        status_reg     <= status_next;
        id_reg         <= id_next;
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
        out_wait_reg   <= out_wait_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{sdtq_pkg::OUT_PAD_W{1'b0}}, out_wait_reg,
                       sdtq_pkg::ID_W'(out_id_reg), out_status_reg};

endmodule

// File: rtl/core/sorted_deadline_timer_queue.sv
// Sorted deadline timer queue, one command beat at a time.
// An add runs a free-slot scan and an insertion walk, a take a list shift, and a finish
// that keeps its timer an insertion walk; every command ends with a front read and a result.
// One command in flight: a new beat is taken only once the controller is back in idle.
// Reset: queue empty, nothing held, min_interval 5, idle_wait 100; no clearing pass.
`timescale 1ns / 1ps

module sorted_deadline_timer_queue
#(
    parameter int MAX_TIMERS = sdtq_pkg::MAX_TIMERS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // now_ms[47:0], interval_ms[78:48], keep[79]
    input  logic [sdtq_pkg::IN_DATA_W-1:0]    s_tdata,
    // command[1:0]
    input  logic [sdtq_pkg::CMD_W-1:0]        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // status[2:0], timer_id[6:3], wait_ms[37:7], zero pad [39:38]
    output logic [sdtq_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  logic                              cfg_we,
    input  logic [sdtq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sdtq_pkg::CFG_DATA_W-1:0]   cfg_data
);

    sdtq_pkg::dp_ctl_t  ctl;
    sdtq_pkg::dp_stat_t stat;

    sdtq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .ctl      (ctl)
    );

    sdtq_datapath #(
        .MAX_TIMERS (MAX_TIMERS)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .stat      (stat),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // one command in flight: busy right after a beat is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a command is in flight");

    a_wait_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[37:7] != '0)
        else $error("reported wait is zero");

    a_id_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[2:0] != sdtq_pkg::ST_OK) |-> m_tdata[6:3] == '0)
        else $error("timer id set on a failed command");

    a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl.decode, ctl.scan, ctl.take_rd, ctl.take_chk, ctl.take_arm,
                  ctl.pop, ctl.ins, ctl.front_rd, ctl.result}))
        else $error("more than one datapath step active");

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for sorted_deadline_timer_queue: directed corner cases, then random
// add/take/finish traffic under several register settings, checked against a built-in predictor.
// Depends on sdtq_pkg and the sorted_deadline_timer_queue RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int NT = sdtq_pkg::MAX_TIMERS_DEF;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int EXP_DEPTH = 16;

    localparam int TIME_W     = sdtq_pkg::TIME_W;
    localparam int WAIT_W     = sdtq_pkg::WAIT_W;
    localparam int ID_W       = sdtq_pkg::ID_W;
    localparam int STATUS_W   = sdtq_pkg::STATUS_W;
    localparam int MIN_IV_W   = sdtq_pkg::MIN_IV_W;
    localparam int IDLE_W     = sdtq_pkg::IDLE_W;
    localparam int CMD_W      = sdtq_pkg::CMD_W;
    localparam int IN_DATA_W  = sdtq_pkg::IN_DATA_W;
    localparam int OUT_DATA_W = sdtq_pkg::OUT_DATA_W;
    localparam int CFG_IDX_W  = sdtq_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = sdtq_pkg::CFG_DATA_W;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    typedef struct packed {
        sdtq_pkg::status_t   status;
        logic [ID_W-1:0]     timer_id;
        logic [WAIT_W-1:0]   wait_ms;
    } timer_reply_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    // now_ms[47:0], interval_ms[78:48], keep[79]
    logic [IN_DATA_W-1:0]   s_tdata;
    // command[1:0]
    logic [CMD_W-1:0]       s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    // status[2:0], timer_id[6:3], wait_ms[37:7], zero pad [39:38]
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // predictor state
    logic [TIME_W-1:0]      dl_mem [NT];
    logic [WAIT_W-1:0]      per_mem [NT];
    logic [ID_W-1:0]        ord_mem [NT];
    int                     q_cnt;
    logic [NT-1:0]          busy;
    logic [ID_W-1:0]        held_id;
    logic                   held_on;
    logic [MIN_IV_W-1:0]    min_iv;
    logic [IDLE_W-1:0]      idle_ms;

    // expected results, oldest at exp_rd
    timer_reply_t           exp_fifo [EXP_DEPTH];
    int                     exp_wr;
    int                     exp_rd;
    timer_reply_t           want;
    logic [TIME_W-1:0]      tb_now;
    int                     burst_left;
    int                     errors;
    int                     n_sent;
    int                     n_checked;
    int                     st_hist [5];
    int                     stall_left;
    int                     ready_phase;
    int                     quiet_cycles;

    sorted_deadline_timer_queue dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ---------------- predictor ----------------

    function automatic logic [TIME_W-1:0] rearm(input logic [TIME_W-1:0] t0,
                                                input logic [WAIT_W-1:0] per);
        logic [TIME_W:0] sum;
        sum = {1'b0, t0} + {{(TIME_W - WAIT_W + 1){1'b0}}, per};
        return sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
    endfunction

    // equal deadlines go behind the ones already queued
    function automatic void enqueue_slot(input logic [ID_W-1:0] slot);
        int pos;
        if (q_cnt >= NT)
            return;
        pos = 0;
        while (pos < q_cnt && dl_mem[ord_mem[pos]] <= dl_mem[slot])
            pos++;
        for (int i = q_cnt; i > pos; i--)
            ord_mem[i] = ord_mem[i - 1];
        ord_mem[pos] = slot;
        q_cnt++;
    endfunction

    function automatic logic [WAIT_W-1:0] front_wait(input logic [TIME_W-1:0] t0);
        logic [TIME_W-1:0] d;
        if (q_cnt == 0)
            return (idle_ms == 0) ? WAIT_W'(1) : WAIT_W'(idle_ms);
        d = dl_mem[ord_mem[0]];
        if (d <= t0)
            return WAIT_W'(1);
        d = d - t0;
        return (d > TIME_W'(sdtq_pkg::WAIT_MAX)) ? sdtq_pkg::WAIT_MAX : d[WAIT_W-1:0];
    endfunction

    function automatic timer_reply_t run_timer_cmd(input sdtq_pkg::cmd_t cmd,
                                                   input logic [TIME_W-1:0] t0,
                                                   input logic [WAIT_W-1:0] iv,
                                                   input logic keep);
        timer_reply_t rep;
        int s;
        rep.status = sdtq_pkg::ST_NONE_DUE;
        rep.timer_id = '0;
        case (cmd)
            sdtq_pkg::CMD_ADD:
            begin
                if (iv < WAIT_W'(min_iv))
                    rep.status = sdtq_pkg::ST_SHORT;
                else
                begin
                    s = 0;
                    while (s < NT && busy[s])
                        s++;
                    if (s >= NT)
                        rep.status = sdtq_pkg::ST_FULL;
                    else
                    begin
                        busy[s] = 1'b1;
                        per_mem[s] = iv;
                        dl_mem[s] = rearm(t0, iv);
                        enqueue_slot(ID_W'(s));
                        rep.status = sdtq_pkg::ST_OK;
                        rep.timer_id = ID_W'(s);
                    end
                end
            end
            sdtq_pkg::CMD_TAKE:
            begin
                if (!held_on && q_cnt > 0)
                begin
                    s = int'(ord_mem[0]);
                    if (dl_mem[s] <= t0)
                    begin
                        for (int i = 1; i < q_cnt; i++)
                            ord_mem[i - 1] = ord_mem[i];
                        q_cnt--;
                        dl_mem[s] = rearm(t0, per_mem[s]);
                        held_id = ID_W'(s);
                        held_on = 1'b1;
                        rep.status = sdtq_pkg::ST_OK;
                        rep.timer_id = ID_W'(s);
                    end
                end
            end
            sdtq_pkg::CMD_FINISH:
            begin
                if (!held_on)
                    rep.status = sdtq_pkg::ST_NOT_HELD;
                else
                begin
                    if (keep)
                        enqueue_slot(held_id);
                    else
                        busy[held_id] = 1'b0;
                    held_on = 1'b0;
                    rep.status = sdtq_pkg::ST_OK;
                    rep.timer_id = held_id;
                end
            end
            default:
            begin
            end
        endcase
        rep.wait_ms = front_wait(t0);
        return rep;
    endfunction

    function automatic void expect_reply(input timer_reply_t rep);
        if (exp_wr - exp_rd >= EXP_DEPTH)
        begin
            $error("expected-result buffer overflow");
            errors++;
        end
        exp_fifo[exp_wr % EXP_DEPTH] = rep;
        exp_wr++;
    endfunction

    // ---------------- drivers ----------------

    task automatic send_cmd(input sdtq_pkg::cmd_t cmd, input logic [TIME_W-1:0] t0,
                            input logic [WAIT_W-1:0] iv, input logic keep);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            burst_left = $urandom_range(1, 30);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {keep, iv, t0};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expect_reply(run_timer_cmd(cmd, t0, iv, keep));
        n_sent++;
    endtask

    task automatic drain_replies();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (exp_wr != exp_rd)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == sdtq_pkg::CFG_MIN_INTERVAL)
            min_iv = val[MIN_IV_W-1:0];
        else
            idle_ms = val[IDLE_W-1:0];
    endtask

    task automatic set_timer_regs(input logic [MIN_IV_W-1:0] min_v, input logic [IDLE_W-1:0] idle_v);
        drain_replies();
        write_reg(sdtq_pkg::CFG_MIN_INTERVAL, CFG_DATA_W'(min_v));
        write_reg(sdtq_pkg::CFG_IDLE_WAIT, idle_v);
    endtask

    // mostly forward steps; rare jumps near the top of the time range or back near zero
    task automatic advance_clock();
        logic [TIME_W:0] sum;
        int j;
        j = $urandom_range(0, 199);
        if (j == 0)
            tb_now = TIME_MAX - TIME_W'($urandom_range(0, 4000));
        else if (j == 1)
            tb_now = TIME_W'($urandom_range(0, 1000));
        else
        begin
            sum = {1'b0, tb_now} + (TIME_W + 1)'($urandom_range(0, (min_iv + 40) / 2));
            tb_now = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
        end
    endtask

    // ---------------- tests ----------------

    task automatic test_empty_and_invalid();
        send_cmd(sdtq_pkg::CMD_FINISH, '0, '0, 1'b1);
        send_cmd(sdtq_pkg::CMD_TAKE, '0, '0, 1'b0);
        send_cmd(sdtq_pkg::CMD_NONE, TIME_MAX, sdtq_pkg::WAIT_MAX, 1'b1);
        send_cmd(sdtq_pkg::CMD_ADD, '0, WAIT_W'(4), 1'b0);
    endtask

    task automatic test_add_take_finish();
        send_cmd(sdtq_pkg::CMD_ADD, '0, WAIT_W'(5), 1'b0);
        send_cmd(sdtq_pkg::CMD_ADD, '0, WAIT_W'(5), 1'b0);
        // deadline saturates at the top of the time range
        send_cmd(sdtq_pkg::CMD_ADD, TIME_MAX, sdtq_pkg::WAIT_MAX, 1'b0);
        send_cmd(sdtq_pkg::CMD_TAKE, TIME_W'(3), '0, 1'b0);
        send_cmd(sdtq_pkg::CMD_TAKE, TIME_W'(5), '0, 1'b0);
        send_cmd(sdtq_pkg::CMD_TAKE, TIME_W'(5), '0, 1'b0);
        send_cmd(sdtq_pkg::CMD_FINISH, TIME_W'(5), '0, 1'b1);
        send_cmd(sdtq_pkg::CMD_TAKE, TIME_W'(7), '0, 1'b0);
        send_cmd(sdtq_pkg::CMD_FINISH, TIME_W'(7), '0, 1'b0);
        // only the far timer left queued: wait saturates
        send_cmd(sdtq_pkg::CMD_TAKE, TIME_W'(10), '0, 1'b0);
        send_cmd(sdtq_pkg::CMD_FINISH, TIME_W'(10), '0, 1'b0);
    endtask

    task automatic test_zero_settings();
        set_timer_regs('0, '0);
        send_cmd(sdtq_pkg::CMD_ADD, TIME_W'(20), '0, 1'b0);
        send_cmd(sdtq_pkg::CMD_TAKE, TIME_W'(20), '0, 1'b0);
        send_cmd(sdtq_pkg::CMD_FINISH, TIME_W'(20), '0, 1'b0);
        send_cmd(sdtq_pkg::CMD_TAKE, TIME_MAX, '0, 1'b0);
        send_cmd(sdtq_pkg::CMD_FINISH, TIME_MAX, '0, 1'b0);
    endtask

    task automatic test_random_traffic(input logic [MIN_IV_W-1:0] min_v,
                                       input logic [IDLE_W-1:0] idle_v, input int n_items);
        sdtq_pkg::cmd_t cmd;
        logic [TIME_W-1:0] t0;
        logic [WAIT_W-1:0] iv;
        logic keep;
        int r;
        int ri;
        set_timer_regs(min_v, idle_v);
        for (int k = 0; k < n_items; k++)
        begin
            r = $urandom_range(0, 99);
            keep = 1'($urandom_range(0, 1));
            iv = WAIT_W'(min_iv + $urandom_range(0, 150));
            if (r < 4)
            begin
                cmd = sdtq_pkg::cmd_t'($urandom_range(0, 3));
                t0 = TIME_W'({$urandom, $urandom});
                iv = WAIT_W'($urandom);
            end
            else
            begin
                advance_clock();
                cmd = sdtq_pkg::CMD_ADD;
                if (held_on)
                    cmd = (r < 88) ? sdtq_pkg::CMD_FINISH
                                   : sdtq_pkg::cmd_t'($urandom_range(0, 1));
                else if (q_cnt > 0 && dl_mem[ord_mem[0]] <= tb_now && r < 75)
                    cmd = sdtq_pkg::CMD_TAKE;
                else if (&busy && r < 60)
                begin
                    // queue full and nothing due: jump ahead to the front deadline
                    tb_now = dl_mem[ord_mem[0]];
                    cmd = sdtq_pkg::CMD_TAKE;
                end
                else
                begin
                    ri = $urandom_range(0, 99);
                    if (ri < 8 && min_iv > 0)
                        iv = WAIT_W'($urandom_range(0, min_iv - 1));
                    else if (ri < 11)
                        iv = WAIT_W'($urandom);
                end
                if (cmd == sdtq_pkg::CMD_FINISH)
                    keep = ($urandom_range(0, 3) != 0);
                t0 = tb_now;
            end
            send_cmd(cmd, t0, iv, keep);
        end
    endtask

    // ---------------- result checker ----------------

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (exp_wr == exp_rd)
            begin
                $error("result beat with no command outstanding: %h", m_tdata);
                errors++;
            end
            else
            begin
                want = exp_fifo[exp_rd % EXP_DEPTH];
                exp_rd++;
                n_checked++;
                st_hist[want.status]++;
                if (m_tdata[STATUS_W-1:0] !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, m_tdata[STATUS_W-1:0]);
                    errors++;
                end
                if (m_tdata[STATUS_W+ID_W-1:STATUS_W] !== want.timer_id)
                begin
                    $error("timer_id: expected %0d, got %0d", want.timer_id,
                           m_tdata[STATUS_W+ID_W-1:STATUS_W]);
                    errors++;
                end
                if (m_tdata[STATUS_W+ID_W+WAIT_W-1:STATUS_W+ID_W] !== want.wait_ms)
                begin
                    $error("wait_ms: expected %0d, got %0d", want.wait_ms,
                           m_tdata[STATUS_W+ID_W+WAIT_W-1:STATUS_W+ID_W]);
                    errors++;
                end
            end
        end
    end

    // receiver: random stalls, apart from a calm stretch at the start of each ready_phase period
    initial
    begin
        m_tready = 1'b0;
        stall_left = 0;
        ready_phase = 0;
        forever
        begin
            @(negedge clk);
            ready_phase++;
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if ((ready_phase % 1024) >= 200 && $urandom_range(0, 99) < 20)
            begin
                stall_left = $urandom_range(0, 11);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("no progress for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, exp_wr - exp_rd);
        $display("FAIL sorted_deadline_timer_queue");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        for (int i = 0; i < NT; i++)
        begin
            dl_mem[i] = '0;
            per_mem[i] = '0;
            ord_mem[i] = '0;
        end
        q_cnt = 0;
        busy = '0;
        held_id = '0;
        held_on = 1'b0;
        min_iv = sdtq_pkg::MIN_IV_RST;
        idle_ms = sdtq_pkg::IDLE_RST;
        exp_wr = 0;
        exp_rd = 0;
        tb_now = '0;
        burst_left = 0;
        errors = 0;
        n_sent = 0;
        n_checked = 0;
        st_hist = '{default: 0};
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_and_invalid();
        test_add_take_finish();
        test_zero_settings();
        test_random_traffic(10'd1, 16'hFFFF, 390);
        test_random_traffic(10'd1000, 16'd1, 390);
        test_random_traffic(MIN_IV_W'($urandom_range(1, 1000)), IDLE_W'($urandom_range(1, 65535)),
                            390);
        test_random_traffic(sdtq_pkg::MIN_IV_RST, sdtq_pkg::IDLE_RST, 390);
        test_random_traffic(MIN_IV_W'($urandom_range(1, 60)), IDLE_W'($urandom_range(1, 65535)),
                            390);

        drain_replies();
        repeat (40) @(posedge clk);
        $display("%0d commands sent, %0d results checked across six register settings",
                 n_sent, n_checked);
        $display("status mix: ok %0d, none due %0d, full %0d, too short %0d, nothing held %0d",
                 st_hist[sdtq_pkg::ST_OK], st_hist[sdtq_pkg::ST_NONE_DUE],
                 st_hist[sdtq_pkg::ST_FULL], st_hist[sdtq_pkg::ST_SHORT],
                 st_hist[sdtq_pkg::ST_NOT_HELD]);
        if (errors == 0)
            $display("PASS sorted_deadline_timer_queue");
        else
            $display("FAIL sorted_deadline_timer_queue");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/sdtq_pkg.sv
rtl/core/sdtq_ctrl.sv
rtl/core/sdtq_datapath.sv
rtl/core/sorted_deadline_timer_queue.sv
tb/sv/tb_top.sv
